@@ rtl/core/gdq_pkg.sv @@
// gdq_pkg: shared types, constants and helpers of the group dequantizer
`default_nettype none

package gdq_pkg;

    localparam int LANES     = 4;
    localparam int COEF_W    = 16;
    localparam int MAG_W     = 15;
    localparam int SHW       = 4;
    localparam int TERMS     = 8;
    localparam int TERMS_LO  = 4;

    localparam logic QT_UNIFORM  = 1'b0;
    localparam logic QT_DEADZONE = 1'b1;

    typedef struct packed {
        logic [COEF_W-1:0] coef0;
        logic [COEF_W-1:0] coef1;
        logic [COEF_W-1:0] coef2;
        logic [COEF_W-1:0] coef3;
        logic [3:0]        gcli;
        logic [3:0]        gtli;
        logic [2:0]        lane_count;
    } in_t;

    typedef struct packed {
        logic [COEF_W-1:0] out0;
        logic [COEF_W-1:0] out1;
        logic [COEF_W-1:0] out2;
        logic [COEF_W-1:0] out3;
    } out_t;

    // group-wide decode, registered at the first stage
    typedef struct packed {
        logic                             active;
        logic                             deadzone;
        logic [LANES-1:0]                 lane_en;
        logic [TERMS-1:1][SHW-1:0]        sh;
        logic [MAG_W-1:0]                 dz_mask;
    } grp_ctrl_t;

    // per lane control handed to each lane datapath
    typedef struct packed {
        logic                             uniform;
        logic                             deadzone;
        logic [TERMS-1:1][SHW-1:0]        sh;
        logic [MAG_W-1:0]                 dz_mask;
    } lane_ctrl_t;

    // magnitude shifted right, zero-extended to the adder width
    function automatic logic [COEF_W-1:0] mag_shr(input logic [MAG_W-1:0] mag,
                                                  input logic [SHW-1:0]   sh);
        logic [MAG_W-1:0] t;
        t = mag >> sh;
        return {1'b0, t};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gdq_decode.sv @@
// gdq_decode: group-level decode of gcli, gtli, lane count and mode
`default_nettype none

module gdq_decode
(
    input  wire logic [3:0]          gcli,
    input  wire logic [3:0]          gtli,
    input  wire logic [2:0]          lane_count,
    input  wire logic                recon_mode,
    output gdq_pkg::grp_ctrl_t       ctrl
);

    logic [4:0] step;
    logic [3:0] dz_bit;

    always_comb
    begin
        logic [7:0] prod;
        prod = 8'd0;
        step   = 5'({1'b0, gcli} - {1'b0, gtli} + 5'd1);
        dz_bit = gtli - 4'd1;
        ctrl.active   = (gtli != 4'd0) && (gcli > gtli);
        ctrl.deadzone = (recon_mode == gdq_pkg::QT_DEADZONE);
        for (int i = 0; i < gdq_pkg::LANES; i++)
        begin
            ctrl.lane_en[i] = (lane_count > 3'(i));
        end
        // shift of term k is k*step, saturated where the term is zero anyway
        for (int k = 1; k < gdq_pkg::TERMS; k++)
        begin
            prod = 8'(k) * {3'b000, step};
            if (prod > 8'd15)
                ctrl.sh[k] = 4'd15;
            else
                ctrl.sh[k] = prod[3:0];
        end
        ctrl.dz_mask = 15'(16'd1 << dz_bit);
    end

endmodule

`default_nettype wire

@@ rtl/core/gdq_lane.sv @@
// gdq_lane: two-stage dequantizer datapath for one coefficient lane
`default_nettype none

module gdq_lane
(
    input  wire logic                           clk,
    input  wire logic [gdq_pkg::COEF_W-1:0]     coef,
    input  wire gdq_pkg::lane_ctrl_t            ctrl,
    output logic      [gdq_pkg::COEF_W-1:0]     result
);

    logic [gdq_pkg::MAG_W-1:0]  mag;
    logic [gdq_pkg::COEF_W-1:0] sum_lo_next;
    logic [gdq_pkg::COEF_W-1:0] sum_lo_reg;
    logic [gdq_pkg::COEF_W-1:0] coef_reg;
    gdq_pkg::lane_ctrl_t        ctrl_reg;
    logic [gdq_pkg::COEF_W-1:0] sum_all;
    logic [gdq_pkg::COEF_W-1:0] result_next;
    logic [gdq_pkg::COEF_W-1:0] result_reg;

    assign mag = coef[gdq_pkg::MAG_W-1:0];

    // first half of the series: m + m>>z + m>>2z + m>>3z
    always_comb
    begin
        sum_lo_next = {1'b0, mag};
        for (int k = 1; k < gdq_pkg::TERMS_LO; k++)
        begin
            sum_lo_next = sum_lo_next + gdq_pkg::mag_shr(mag, ctrl.sh[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_lo_reg <= sum_lo_next;
        coef_reg   <= coef;
        ctrl_reg   <= ctrl;
    end

    // second half of the series and final selection
    always_comb
    begin
        logic [gdq_pkg::MAG_W-1:0] m;
        m = coef_reg[gdq_pkg::MAG_W-1:0];
        sum_all = sum_lo_reg;
        for (int k = gdq_pkg::TERMS_LO; k < gdq_pkg::TERMS; k++)
        begin
            sum_all = sum_all + gdq_pkg::mag_shr(m, ctrl_reg.sh[k]);
        end
        if (m == '0)
            result_next = coef_reg;
        else if (ctrl_reg.uniform)
            result_next = sum_all | {coef_reg[gdq_pkg::COEF_W-1], 15'd0};
        else if (ctrl_reg.deadzone)
            result_next = coef_reg | {1'b0, ctrl_reg.dz_mask};
        else
            result_next = coef_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/core/group_dequantizer_unit.sv @@
// group_dequantizer_unit: pipelined inverse quantizer for groups of four coefficients
//
//  channel   | ports                    | transfer
//  ----------+--------------------------+------------------------------------
//  input     | start, busy, in_item     | edge with start high and busy low
//  result    | done, result             | edge ending the cycle done is high
//  config    | cfg_we, cfg_wdata        | edge with cfg_we high
//
//  one group enters every cycle; busy is always low
//  a group passes the decode register, lane stage one and lane stage two, in that order
//  every stage takes a new group each cycle; the lane adder series is split over two stages
//  reset clears the valid bits and the mode register (uniform)
//  the receiver cannot stall, so results leave in input order at one per cycle
`default_nettype none

module group_dequantizer_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire gdq_pkg::in_t  in_item,
    output logic               done,
    output gdq_pkg::out_t      result,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata
);

    logic                       recon_mode_reg;
    logic                       accept;
    logic [2:0]                 valid_reg;
    gdq_pkg::grp_ctrl_t         ctrl_next;
    gdq_pkg::grp_ctrl_t         ctrl_reg;
    logic [gdq_pkg::LANES-1:0][gdq_pkg::COEF_W-1:0] coef_reg;
    logic [gdq_pkg::COEF_W-1:0] lane_out [gdq_pkg::LANES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            recon_mode_reg <= gdq_pkg::QT_UNIFORM;
        else if (cfg_we)
            recon_mode_reg <= cfg_wdata;
    end

    gdq_decode u_decode
    (
        .gcli       (in_item.gcli),
        .gtli       (in_item.gtli),
        .lane_count (in_item.lane_count),
        .recon_mode (recon_mode_reg),
        .ctrl       (ctrl_next)
    );

    // valid bits travel alongside the three data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 3'b000;
        else
            valid_reg <= {valid_reg[1:0], accept};
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg    <= ctrl_next;
        coef_reg[0] <= in_item.coef0;
        coef_reg[1] <= in_item.coef1;
        coef_reg[2] <= in_item.coef2;
        coef_reg[3] <= in_item.coef3;
    end

    for (genvar i = 0; i < gdq_pkg::LANES; i++)
    begin : g_lane
        gdq_pkg::lane_ctrl_t lctrl;

        always_comb
        begin
            lctrl.uniform  = ctrl_reg.active && ctrl_reg.lane_en[i] && !ctrl_reg.deadzone;
            lctrl.deadzone = ctrl_reg.active && ctrl_reg.lane_en[i] && ctrl_reg.deadzone;
            lctrl.sh       = ctrl_reg.sh;
            lctrl.dz_mask  = ctrl_reg.dz_mask;
        end

        gdq_lane u_lane
        (
            .clk    (clk),
            .coef   (coef_reg[i]),
            .ctrl   (lctrl),
            .result (lane_out[i])
        );
    end

    assign done   = valid_reg[2];
    assign result = {lane_out[0], lane_out[1], lane_out[2], lane_out[3]};

endmodule

`default_nettype wire
